// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros shared by the RTL core.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check sampled on the rising clock edge, off while in reset
`define DRS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("drs check failed");

// Check that a condition never holds while out of reset
`define DRS_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("drs forbidden condition");

`endif

// ===== rtl/core/drs_pkg.sv =====
// Package for the dome reply stream decoder: codes, constants and the
// beat structures passed between the core and the top level. No dependencies.
package drs_pkg;

   // Record and number geometry
   localparam int RECORD_FIELDS = 23;
   localparam int NUMBER_CHARS  = 4;
   localparam int FIELD_W       = 5;
   localparam int CHARS_W       = 3;

   // Record fields that are kept (zero-based index)
   localparam int KEEP_TICK    = 1;
   localparam int KEEP_AZIMUTH = 4;
   localparam int KEEP_SHUTTER = 6;

   // Saturation limits
   localparam logic [15:0] NUM_MAX  = 16'd9999;
   localparam logic [15:0] MAG_MAX  = 16'd32768;
   localparam logic [15:0] POS_MAX  = 16'd32767;

   // Item opcodes
   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_BYTE    = 1'b1;

   // ASCII characters of the reply protocol
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      CMD_IDLE,
      CMD_CLOSING,
      CMD_OPENING,
      CMD_MOVING,
      CMD_HOMING
   } drs_cmd_type;

   typedef enum logic [1:0] {
      CAP_NONE,
      CAP_POS,
      CAP_Z,
      CAP_REC
   } drs_capture_type;

   typedef enum logic [2:0] {
      KIND_PROGRESS,
      KIND_POSITION,
      KIND_SHUTTER,
      KIND_INFO,
      KIND_ERROR,
      KIND_MALFORMED
   } drs_kind_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
      logic [2:0] new_command;
   } drs_item_type;

   typedef struct packed {
      drs_kind_type       kind;
      logic [13:0]        number;
      logic signed [15:0] shutter_state;
      logic signed [15:0] tick_total;
      logic signed [15:0] azimuth_ticks;
      logic               command_done;
      drs_cmd_type        command_now;
   } drs_result_type;

endpackage

// ===== rtl/core/dome_reply_stream_decoder.sv =====
// Decodes a stream of dome-controller command starts and reply bytes into
// result beats. One beat is accepted per clock unless the pipe is stalled: each
// beat is held in an input register, is decoded in a single pass of the core
// logic and any result lands in the output register, which drives rsp_tvalid;
// throughput is one beat per cycle while rsp_tready is high. Only the output
// register stalling holds the pipe.
// Depends on drs_pkg, drs_core and assert_macros.svh.
`include "assert_macros.svh"

module dome_reply_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] rx_byte, [10:8] new_command, rest zero
   input  logic        req_tuser,  // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // [13:0] number, [29:14] shutter_state,
                                   // [45:30] tick_total, [61:46] azimuth_ticks,
                                   // [62] command_done, [65:63] command_now, rest zero
   output logic [2:0]  rsp_tuser   // [2:0] kind
);
   import drs_pkg::*;

   logic           in_valid_ff, in_valid_in;
   drs_item_type   in_item_ff;
   logic           out_valid_ff, out_valid_in;
   drs_result_type out_res_ff;
   logic           fire;
   logic           res_valid;
   drs_result_type res;

   // Decode stage runs when the output register can take its result
   assign fire        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);
   assign out_valid_in = fire ? res_valid : (out_valid_ff && !rsp_tready);

   drs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_item_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_item_ff.opcode      <= req_tuser;
         in_item_ff.rx_byte     <= req_tdata[7:0];
         in_item_ff.new_command <= req_tdata[10:8];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (fire && res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.kind;
   assign rsp_tdata  = {6'd0, out_res_ff.command_now, out_res_ff.command_done,
                        out_res_ff.azimuth_ticks, out_res_ff.tick_total,
                        out_res_ff.shutter_state, out_res_ff.number};

   // A held decode beat must block new input
   `DRS_ASSERT(a_stall_blocks_input, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)

endmodule

// ===== rtl/core/drs_core.sv =====
// Decoder core: command/capture state and the per-beat decode logic.
// Depends on drs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module drs_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  drs_pkg::drs_item_type  item,
   output logic                   res_valid,
   output drs_pkg::drs_result_type res
);
   import drs_pkg::*;

   drs_cmd_type     cmd_ff, cmd_in;
   drs_capture_type cap_ff, cap_in;
   logic [FIELD_W-1:0] field_ff, field_in;
   logic [CHARS_W-1:0] chars_ff, chars_in;
   logic [15:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        bad_ff, bad_in;
   logic [15:0] tick_ff, tick_in;
   logic [15:0] az_ff, az_in;
   logic [15:0] shut_ff, shut_in;

   // Shared arithmetic helpers
   logic        is_digit;
   logic [3:0]  digit_val;
   logic [19:0] acc_mul;
   logic [15:0] acc_num, acc_rec;
   logic [15:0] field_val;
   logic [15:0] tick_c, az_c, shut_c;
   logic        bad_c;
   logic [FIELD_W-1:0] field_inc;
   logic        rec_ok;

   assign is_digit  = (item.rx_byte >= CH_ZERO) && (item.rx_byte <= CH_NINE);
   assign digit_val = 4'(item.rx_byte - CH_ZERO);
   assign acc_mul   = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + {16'd0, digit_val};
   assign acc_num   = (acc_mul > {4'd0, NUM_MAX}) ? NUM_MAX : acc_mul[15:0];
   assign acc_rec   = (acc_mul > {4'd0, MAG_MAX}) ? MAG_MAX : acc_mul[15:0];

   // Field close: signed value, kept-field capture, empty-field check
   assign field_val = neg_ff ? (16'd0 - acc_ff) : ((acc_ff > POS_MAX) ? POS_MAX : acc_ff);
   assign tick_c = (chars_ff[1] && field_ff == FIELD_W'(KEEP_TICK)) ? field_val : tick_ff;
   assign az_c   = (chars_ff[1] && field_ff == FIELD_W'(KEEP_AZIMUTH)) ? field_val : az_ff;
   assign shut_c = (chars_ff[1] && field_ff == FIELD_W'(KEEP_SHUTTER)) ? field_val : shut_ff;
   assign bad_c  = bad_ff | ~chars_ff[1];
   assign field_inc = (field_ff != {FIELD_W{1'b1}}) ? field_ff + 1'b1 : field_ff;
   assign rec_ok = !bad_c && ({1'b0, field_ff} + 1'b1 == (FIELD_W+1)'(RECORD_FIELDS));

   // Next state and result for one beat
   always_comb begin
      cmd_in    = cmd_ff;
      cap_in    = cap_ff;
      field_in  = field_ff;
      chars_in  = chars_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      bad_in    = bad_ff;
      tick_in   = tick_ff;
      az_in     = az_ff;
      shut_in   = shut_ff;
      res_valid = 1'b0;
      res       = '0;

      if (item.opcode == OP_COMMAND) begin
         cmd_in = (item.new_command <= CMD_HOMING) ? drs_cmd_type'(item.new_command) : CMD_IDLE;
         cap_in = CAP_NONE;
         field_in = '0; chars_in = '0; acc_in = '0; neg_in = 1'b0; bad_in = 1'b0;
         tick_in = '0; az_in = '0; shut_in = '0;
      end else begin
         unique case (cap_ff)
            CAP_POS, CAP_Z: begin
               if (item.rx_byte == CH_CR) begin
                  res_valid  = 1'b1;
                  res.kind   = (cap_ff == CAP_POS) ? KIND_POSITION : KIND_SHUTTER;
                  res.number = acc_ff[13:0];
                  cap_in = CAP_NONE;
                  field_in = '0; chars_in = '0; acc_in = '0; neg_in = 1'b0; bad_in = 1'b0;
                  tick_in = '0; az_in = '0; shut_in = '0;
               end else if (chars_ff < CHARS_W'(NUMBER_CHARS)) begin
                  chars_in = chars_ff + 1'b1;
                  if (!is_digit) begin
                     neg_in = 1'b1;
                  end else if (!neg_ff) begin
                     acc_in = acc_num;
                  end
               end
            end
            CAP_REC: begin
               if (is_digit) begin
                  acc_in = acc_rec;
                  chars_in = chars_ff | CHARS_W'(2);
               end else if (item.rx_byte == CH_MINUS || item.rx_byte == CH_PLUS) begin
                  if (chars_ff[2] || chars_ff[1]) bad_in = 1'b1;
                  chars_in = chars_ff | CHARS_W'(4);
                  neg_in = (item.rx_byte == CH_MINUS);
               end else if (item.rx_byte == CH_COMMA) begin
                  tick_in = tick_c; az_in = az_c; shut_in = shut_c;
                  acc_in = '0; neg_in = 1'b0;
                  chars_in = {{(CHARS_W-1){1'b0}}, chars_ff[0]};
                  field_in = field_inc;
                  bad_in = bad_c | ({1'b0, field_inc} >= (FIELD_W+1)'(RECORD_FIELDS));
               end else if (item.rx_byte == CH_CR) begin
                  res_valid = 1'b1;
                  res.command_done = chars_ff[0];
                  if (rec_ok) begin
                     res.kind          = KIND_INFO;
                     res.tick_total    = tick_c;
                     res.azimuth_ticks = az_c;
                     res.shutter_state = shut_c;
                  end else begin
                     res.kind = KIND_MALFORMED;
                  end
                  cap_in = CAP_NONE;
                  field_in = '0; chars_in = '0; acc_in = '0; neg_in = 1'b0; bad_in = 1'b0;
                  tick_in = '0; az_in = '0; shut_in = '0;
               end else begin
                  bad_in = 1'b1;
               end
            end
            CAP_NONE: begin
               if (cmd_ff == CMD_IDLE) begin
                  if (item.rx_byte == CH_V) begin
                     cap_in = CAP_REC;
                     field_in = '0; chars_in = '0; acc_in = '0; neg_in = 1'b0; bad_in = 1'b0;
                     tick_in = '0; az_in = '0; shut_in = '0;
                  end
               end else begin
                  case (item.rx_byte) inside
                     CH_S, CH_T: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_PROGRESS;
                     end
                     CH_O: begin
                        res_valid = 1'b1;
                        if (cmd_ff == CMD_OPENING) begin
                           res.kind = KIND_PROGRESS;
                        end else begin
                           res.kind = KIND_ERROR;
                           cmd_in   = CMD_IDLE;
                        end
                     end
                     CH_C: begin
                        res_valid = 1'b1;
                        if (cmd_ff == CMD_CLOSING) begin
                           res.kind = KIND_PROGRESS;
                        end else begin
                           res.kind = KIND_ERROR;
                           cmd_in   = CMD_IDLE;
                        end
                     end
                     CH_P, CH_Z: begin
                        cap_in = (item.rx_byte == CH_P) ? CAP_POS : CAP_Z;
                        field_in = '0; chars_in = '0; acc_in = '0; neg_in = 1'b0; bad_in = 1'b0;
                        tick_in = '0; az_in = '0; shut_in = '0;
                     end
                     CH_V: begin
                        cmd_in = CMD_IDLE;
                        cap_in = CAP_REC;
                        field_in = '0; chars_in = CHARS_W'(1); acc_in = '0;
                        neg_in = 1'b0; bad_in = 1'b0;
                        tick_in = '0; az_in = '0; shut_in = '0;
                     end
                     default: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_ERROR;
                        cmd_in    = CMD_IDLE;
                     end
                  endcase
               end
            end
            default: begin
               cap_in = CAP_NONE;
            end
         endcase
      end
      res.command_now = cmd_in;
   end

   // State registers advance only on a processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= CMD_IDLE;
         cap_ff   <= CAP_NONE;
         field_ff <= '0;
         chars_ff <= '0;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         bad_ff   <= 1'b0;
         tick_ff  <= '0;
         az_ff    <= '0;
         shut_ff  <= '0;
      end else if (fire) begin
         cmd_ff   <= cmd_in;
         cap_ff   <= cap_in;
         field_ff <= field_in;
         chars_ff <= chars_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         bad_ff   <= bad_in;
         tick_ff  <= tick_in;
         az_ff    <= az_in;
         shut_ff  <= shut_in;
      end
   end

   // A command start always drops any capture in progress
   `DRS_ASSERT(a_cmd_clears_capture, clock, reset,
      fire && item.opcode == OP_COMMAND |=> cap_ff == CAP_NONE)
   // An error always leaves the block idle
   `DRS_ASSERT(a_error_goes_idle, clock, reset,
      res_valid && res.kind == KIND_ERROR |-> res.command_now == CMD_IDLE)
   // command_done only accompanies record results
   `DRS_NEVER(a_done_only_on_record, clock, reset,
      res_valid && res.command_done && res.kind != KIND_INFO && res.kind != KIND_MALFORMED)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the dome reply stream decoder.
// Drives command and reply-byte beats, predicts every result beat in a small
// scoreboard class and checks the result stream. Depends on drs_pkg and the RTL.
module tb_top;
   import drs_pkg::*;

   // Reply tracker: mirrors the decoder state and holds the replies still due
   class reply_tracker;
      drs_cmd_type     cur_cmd;
      drs_capture_type cap;
      logic [4:0]      fields_done;
      logic [2:0]      chars;      // record: [0] command done, [1] digit, [2] sign
      logic [15:0]     acc;
      logic            neg;
      logic            bad;
      logic [15:0]     kept [3];   // tick total, azimuth ticks, shutter
      drs_result_type  replies_due[$];
      int              mismatches;

      function new();
         cur_cmd    = CMD_IDLE;
         mismatches = 0;
         restart_capture(CAP_NONE, 1'b0);
      endfunction

      function void restart_capture(drs_capture_type mode, logic done_bit);
         cap         = mode;
         fields_done = '0;
         chars       = {2'b00, done_bit};
         acc         = '0;
         neg         = 1'b0;
         bad         = 1'b0;
         foreach (kept[i]) kept[i] = '0;
      endfunction

      // Finish one record field: saturate, negate and keep the ones reported
      function void close_field();
         logic [15:0] v;
         if (!chars[1]) begin
            bad = 1'b1;
         end else begin
            v = neg ? (~acc + 16'd1) : ((acc > POS_MAX) ? POS_MAX : acc);
            if (fields_done == KEEP_TICK) kept[0] = v;
            else if (fields_done == KEEP_AZIMUTH) kept[1] = v;
            else if (fields_done == KEEP_SHUTTER) kept[2] = v;
         end
         acc        = '0;
         neg        = 1'b0;
         chars[2:1] = 2'b00;
      endfunction

      function drs_result_type make_reply(drs_kind_type k, logic [13:0] num,
                                          logic [15:0] sh, logic [15:0] tt,
                                          logic [15:0] az, logic done_bit);
         drs_result_type r;
         r.kind          = k;
         r.number        = num;
         r.shutter_state = sh;
         r.tick_total    = tt;
         r.azimuth_ticks = az;
         r.command_done  = done_bit;
         r.command_now   = cur_cmd;
         return r;
      endfunction

      // Advance the mirrored state by one accepted beat
      function void note_item(logic op, logic [7:0] c, logic [2:0] nc);
         logic           is_digit;
         logic           done_bit;
         logic           fault;
         logic [31:0]    sum;
         logic [15:0]    val;
         drs_kind_type   k;
         drs_result_type r;
         is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
         sum      = 32'(acc) * 32'd10 + 32'(c - CH_ZERO);
         if (op == OP_COMMAND) begin
            cur_cmd = (nc > 3'd4) ? CMD_IDLE : drs_cmd_type'(nc);
            restart_capture(CAP_NONE, 1'b0);
         end else if (cap == CAP_POS || cap == CAP_Z) begin
            // short decimal number after P or Z
            if (c == CH_CR) begin
               k   = (cap == CAP_POS) ? KIND_POSITION : KIND_SHUTTER;
               val = acc;
               restart_capture(CAP_NONE, 1'b0);
               replies_due.push_back(make_reply(k, val[13:0], '0, '0, '0, 1'b0));
            end else if (chars < NUMBER_CHARS) begin
               chars++;
               if (!is_digit) neg = 1'b1;
               else if (!neg) acc = (sum > NUM_MAX) ? NUM_MAX : sum[15:0];
            end
         end else if (cap == CAP_REC) begin
            // comma-separated info record
            if (is_digit) begin
               acc      = (sum > MAG_MAX) ? MAG_MAX : sum[15:0];
               chars[1] = 1'b1;
            end else if (c == CH_MINUS || c == CH_PLUS) begin
               if (chars[2:1] != 2'b00) bad = 1'b1;
               chars[2] = 1'b1;
               neg      = (c == CH_MINUS);
            end else if (c == CH_COMMA) begin
               close_field();
               if (fields_done < 5'd31) fields_done++;
               if (fields_done >= RECORD_FIELDS) bad = 1'b1;
            end else if (c == CH_CR) begin
               done_bit = chars[0];
               close_field();
               if (!bad && int'(fields_done) + 1 == RECORD_FIELDS)
                  r = make_reply(KIND_INFO, '0, kept[2], kept[0], kept[1], done_bit);
               else
                  r = make_reply(KIND_MALFORMED, '0, '0, '0, '0, done_bit);
               restart_capture(CAP_NONE, 1'b0);
               replies_due.push_back(r);
            end else begin
               bad = 1'b1;
            end
         end else if (cur_cmd == CMD_IDLE) begin
            if (c == CH_V) restart_capture(CAP_REC, 1'b0);
         end else begin
            // byte while a command runs
            fault = 1'b0;
            case (c)
               CH_S, CH_T: replies_due.push_back(make_reply(KIND_PROGRESS, '0, '0, '0,
                                                            '0, 1'b0));
               CH_O: begin
                  if (cur_cmd == CMD_OPENING)
                     replies_due.push_back(make_reply(KIND_PROGRESS, '0, '0, '0, '0, 1'b0));
                  else
                     fault = 1'b1;
               end
               CH_C: begin
                  if (cur_cmd == CMD_CLOSING)
                     replies_due.push_back(make_reply(KIND_PROGRESS, '0, '0, '0, '0, 1'b0));
                  else
                     fault = 1'b1;
               end
               CH_P: restart_capture(CAP_POS, 1'b0);
               CH_Z: restart_capture(CAP_Z, 1'b0);
               CH_V: begin
                  cur_cmd = CMD_IDLE;
                  restart_capture(CAP_REC, 1'b1);
               end
               default: fault = 1'b1;
            endcase
            if (fault) begin
               cur_cmd = CMD_IDLE;
               replies_due.push_back(make_reply(KIND_ERROR, '0, '0, '0, '0, 1'b0));
            end
         end
      endfunction

      // Compare one result beat with the oldest reply due
      function void check_reply(logic [71:0] data, logic [2:0] user);
         drs_result_type want;
         drs_result_type got;
         got.kind          = drs_kind_type'(user);
         got.number        = data[13:0];
         got.shutter_state = data[29:14];
         got.tick_total    = data[45:30];
         got.azimuth_ticks = data[61:46];
         got.command_done  = data[62];
         got.command_now   = drs_cmd_type'(data[65:63]);
         if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reply beat: kind=%0d data=%h", user, data);
            return;
         end
         want = replies_due.pop_front();
         if (got.kind !== want.kind || got.number !== want.number ||
             got.shutter_state !== want.shutter_state ||
             got.tick_total !== want.tick_total ||
             got.azimuth_ticks !== want.azimuth_ticks ||
             got.command_done !== want.command_done ||
             got.command_now !== want.command_now) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("reply mismatch: want kind=%0d num=%0d sh=%0d tt=%0d az=%0d done=%0d cmd=%0d",
                        want.kind, want.number, want.shutter_state, want.tick_total,
                        want.azimuth_ticks, want.command_done, want.command_now);
               $display("                got  kind=%0d num=%0d sh=%0d tt=%0d az=%0d done=%0d cmd=%0d",
                        got.kind, got.number, got.shutter_state, got.tick_total,
                        got.azimuth_ticks, got.command_done, got.command_now);
            end
         end
      endfunction
   endclass

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 2000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;  // [7:0] rx_byte, [10:8] new_command, rest zero
   logic        req_tuser  = 1'b0; // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // [13:0] number, [29:14] shutter_state,
                                  // [45:30] tick_total, [61:46] azimuth_ticks,
                                  // [62] command_done, [65:63] command_now
   logic [2:0]  rsp_tuser;        // [2:0] kind

   reply_tracker tracker = new();
   int   items_sent = 0;
   int   cycles     = 0;
   logic calm_tx    = 1'b0;
   logic calm_rx    = 1'b0;
   int   hold_asks  = 0;
   int   hold_seen  = 0;
   int   hold_left  = 0;

   dome_reply_stream_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side: check accepted beats, random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) tracker.check_reply(rsp_tdata, rsp_tuser);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm_rx || ($urandom_range(99) >= 27);
         end
      end
   end

   // Offer one beat after a random gap and wait for it to be taken
   task automatic send_item(input logic op, input logic [7:0] b, input logic [2:0] nc);
      int gap;
      gap = 0;
      if (!calm_tx) while ($urandom_range(99) < 27) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, nc, b};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      tracker.note_item(op, b, nc);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(OP_BYTE, b, 3'($urandom_range(7)));
   endtask

   task automatic send_command(input logic [2:0] nc);
      send_item(OP_COMMAND, 8'($urandom), nc);
   endtask

   function automatic logic [7:0] progress_letter();
      case ($urandom_range(3))
         0: return CH_S;
         1: return CH_T;
         2: return CH_O;
         default: return CH_C;
      endcase
   endfunction

   // P or Z, up to six characters (mostly digits), then CR
   task automatic send_number(input logic [7:0] lead);
      logic [7:0] b;
      send_byte(lead);
      repeat ($urandom_range(6)) begin
         if ($urandom_range(99) < 85) begin
            b = 8'(CH_ZERO + $urandom_range(9));
         end else begin
            b = 8'($urandom);
            if (b == CH_CR) b = CH_PLUS;
         end
         send_byte(b);
      end
      send_byte(CH_CR);
   endtask

   // V, a record of signed fields, then CR; glitchy records can carry broken fields
   task automatic send_record(input int n_fields, input bit glitchy);
      logic [7:0] b;
      int         value;
      int         pick;
      string      s;
      send_byte(CH_V);
      for (int i = 0; i < n_fields; i++) begin
         if (i > 0) send_byte(CH_COMMA);
         pick = glitchy ? $urandom_range(19) : 19;
         case ($urandom_range(7))
            0: value = 0;
            1: value = 32767;
            2: value = 32768;
            3: value = 99999;
            4: value = $urandom_range(999999);
            default: value = $urandom_range(3000);
         endcase
         s = $sformatf("%0d", value);
         case (pick)
            0: ;   // empty field
            1: begin
               // doubled sign
               send_byte(CH_PLUS);
               send_byte(CH_MINUS);
               send_byte(s[0]);
            end
            2: begin
               // sign after the digits
               send_byte(s[0]);
               send_byte(CH_MINUS);
            end
            3: begin
               // stray byte inside the field
               do b = 8'($urandom);
               while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_PLUS || b == CH_MINUS ||
                      b == CH_COMMA || b == CH_CR);
               send_byte(s[0]);
               send_byte(b);
            end
            default: begin
               case ($urandom_range(5))
                  0, 1: send_byte(CH_MINUS);
                  2: send_byte(CH_PLUS);
                  default: ;
               endcase
               for (int j = 0; j < s.len(); j++) send_byte(s[j]);
            end
         endcase
      end
      send_byte(CH_CR);
   endtask

   function automatic int record_length();
      return ($urandom_range(99) < 75) ? RECORD_FIELDS : $urandom_range(34);
   endfunction

   // Stimulus
   initial begin
      bit hold_done;
      int goal;
      hold_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle bytes, empty record, matching and mismatching letters,
      // numbers cut short and running long, out-of-range commands, bad bytes
      send_byte(CH_S);
      send_byte(8'hFF);
      send_byte(CH_V);
      send_byte(CH_CR);
      send_command(CMD_OPENING);
      send_byte(CH_O);
      send_byte(CH_C);
      send_command(CMD_CLOSING);
      send_byte(CH_C);
      send_byte(CH_S);
      send_byte(CH_T);
      send_command(3'd7);
      send_command(CMD_MOVING);
      send_byte(CH_P);
      send_byte(CH_MINUS);
      send_byte(CH_CR);
      send_byte(CH_Z);
      repeat (5) send_byte(CH_NINE);
      send_byte(CH_CR);
      send_command(CMD_HOMING);
      send_byte(8'h00);

      // Random part: mostly well-formed sessions, some noise
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         calm_tx <= (items_sent >= goal - 1400) && (items_sent < goal - 900);
         calm_rx <= (items_sent >= goal - 1400) && (items_sent < goal - 900);
         if (!hold_done && items_sent >= goal - 1200) begin
            hold_asks <= hold_asks + 1;
            hold_done = 1'b1;
         end
         case ($urandom_range(9))
            0: send_command(3'($urandom_range(7)));
            1, 2: send_byte(progress_letter());
            3: send_number($urandom_range(1) ? CH_P : CH_Z);
            4: send_byte(8'($urandom));
            5: send_record(record_length(), $urandom_range(99) < 20);
            default: begin
               // command session ended by a record, an error or a new command
               send_command(3'($urandom_range(1, 4)));
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(1)) send_byte(progress_letter());
                  else send_number($urandom_range(1) ? CH_P : CH_Z);
               end
               case ($urandom_range(7))
                  6: send_byte(8'($urandom));
                  7: send_command(3'($urandom_range(7)));
                  default: send_record(record_length(), $urandom_range(99) < 20);
               endcase
            end
         endcase
      end
      req_tvalid <= 1'b0;

      // Drain, then allow the pipeline latency for any stray beat
      while (tracker.replies_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
